// ===== rtl/core/hs_pkg.sv =====
// heap sorter package: sequencer state encoding
package hs_pkg;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_START,
      ST_BUILD,
      ST_RD_NODE,
      ST_GET_NODE,
      ST_DESCEND,
      ST_GET_LEFT,
      ST_GET_RIGHT,
      ST_CMP,
      ST_NEXT,
      ST_EXTRACT,
      ST_EX_RD0,
      ST_EX_RDL,
      ST_EX_SWAP,
      ST_EMIT_RD,
      ST_EMIT_LOAD
   } state_type;

endpackage

// ===== rtl/core/hs_store.sv =====
// heap sorter element store: one write port, one registered read port
module hs_store #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/heap_sorter.sv =====
// heap sorter top level: load, in-place heapsort and sorted readout
//
// usage:
//  - req channel carries one signed value per item plus req_last on the final
//    item of a set; up to CAPACITY values are kept, further ones are dropped
//    and every result of that set then shows rsp_overflowed
//  - loading accepts one item per cycle; req_stall is low only while loading
//  - the final item starts an in-place heapsort: build a max-heap, then move
//    the root to the end and sift down the shrunken heap, n-1 times
//  - each sift level reads the left child, reads the right child (if any), compares
//    and writes back, on the store's one read port and the one comparator
//  - results come out in ascending signed order, each read from the store and
//    then loaded into the result register, with rsp_last_res on the greatest value
//  - the result register holds while rsp_stall is high; the sequencer waits
//    on it, and once the final result is loaded the block takes a new set
//  - reset (synchronous, active high) empties the set, clears the overflow
//    flag and drops any pending result; store contents are not cleared
module heap_sorter #(
   parameter int CAPACITY   = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [DATA_WIDTH-1:0] req_value,
   input  logic                         req_last,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [DATA_WIDTH-1:0] rsp_value_res,
   output logic                         rsp_last_res,
   output logic                         rsp_overflowed
);
   import hs_pkg::*;

   localparam int AW = $clog2(CAPACITY);     // store address width
   localparam int CW = $clog2(CAPACITY + 1); // count width, holds CAPACITY
   localparam int LW = CW + 1;               // child index width

   // sequencer state and counters
   state_type              state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic                   ovf_ff, ovf_in;
   logic [CW-1:0]          k_ff, k_in;          // heap build / extract counter
   logic                   build_ff, build_in;  // 1 while building the heap
   logic [AW-1:0]          node_ff, node_in;    // hole being sifted down
   logic [CW-1:0]          size_ff, size_in;    // current heap size
   logic [AW-1:0]          emit_ff, emit_in;    // readout index

   // datapath registers
   logic [DATA_WIDTH-1:0]  cur_ff, cur_in;      // value being sifted
   logic [DATA_WIDTH-1:0]  best_ff, best_in;    // larger child so far
   logic [AW-1:0]          best_idx_ff, best_idx_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0]  rsp_value_ff, rsp_value_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   rsp_ovf_ff, rsp_ovf_in;

   // store port
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [DATA_WIDTH-1:0]  wr_data;
   logic                   rd_en;
   logic [AW-1:0]          rd_addr;
   logic [DATA_WIDTH-1:0]  rd_data;

   // shared comparator
   logic [DATA_WIDTH-1:0]  cmp_a;
   logic [DATA_WIDTH-1:0]  cmp_b;
   logic                   cmp_gt;

   logic                   req_accept;
   logic                   rsp_free;
   logic [LW-1:0]          lc;
   logic [LW-1:0]          rc;
   logic                   lc_in_heap;
   logic                   rc_in_heap;
   logic                   emit_last;

   hs_store #(
      .DEPTH (CAPACITY),
      .WIDTH (DATA_WIDTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_stall  = (state_ff != ST_LOAD);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // children of the current hole
   assign lc         = LW'({node_ff, 1'b1});
   assign rc         = lc + LW'(1);
   assign lc_in_heap = lc < LW'(size_ff);
   assign rc_in_heap = rc < LW'(size_ff);
   assign emit_last  = (CW'(emit_ff) + CW'(1)) == count_ff;

   // the one compare unit: right child against left, then child against hole
   always_comb begin
      if (state_ff == ST_GET_RIGHT) begin
         cmp_a = rd_data;
         cmp_b = best_ff;
      end else begin
         cmp_a = best_ff;
         cmp_b = cur_ff;
      end
   end
   assign cmp_gt = $signed(cmp_a) > $signed(cmp_b);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_accept && req_last) begin
               state_in = ST_START;
            end
         end
         ST_START:     state_in = ST_BUILD;
         ST_BUILD: begin
            state_in = (k_ff == '0) ? ST_EXTRACT : ST_RD_NODE;
         end
         ST_RD_NODE:   state_in = ST_GET_NODE;
         ST_GET_NODE:  state_in = ST_DESCEND;
         ST_DESCEND: begin
            state_in = lc_in_heap ? ST_GET_LEFT : ST_NEXT;
         end
         ST_GET_LEFT: begin
            state_in = rc_in_heap ? ST_GET_RIGHT : ST_CMP;
         end
         ST_GET_RIGHT: state_in = ST_CMP;
         ST_CMP: begin
            state_in = cmp_gt ? ST_DESCEND : ST_NEXT;
         end
         ST_NEXT: begin
            state_in = build_ff ? ST_BUILD : ST_EXTRACT;
         end
         ST_EXTRACT: begin
            state_in = (k_ff > CW'(1)) ? ST_EX_RD0 : ST_EMIT_RD;
         end
         ST_EX_RD0:    state_in = ST_EX_RDL;
         ST_EX_RDL:    state_in = ST_EX_SWAP;
         ST_EX_SWAP:   state_in = ST_DESCEND;
         ST_EMIT_RD:   state_in = ST_EMIT_LOAD;
         ST_EMIT_LOAD: begin
            if (rsp_free) begin
               state_in = emit_last ? ST_LOAD : ST_EMIT_RD;
            end
         end
         default:      state_in = ST_LOAD;
      endcase
   end

   // datapath and store control
   always_comb begin
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      k_in         = k_ff;
      build_in     = build_ff;
      node_in      = node_ff;
      size_in      = size_ff;
      emit_in      = emit_ff;
      cur_in       = cur_ff;
      best_in      = best_ff;
      best_idx_in  = best_idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      wr_en        = 1'b0;
      wr_addr      = node_ff;
      wr_data      = cur_ff;
      rd_en        = 1'b0;
      rd_addr      = node_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_accept) begin
               if (count_ff < CW'(CAPACITY)) begin
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[AW-1:0];
                  wr_data  = req_value;
                  count_in = count_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
         end
         ST_START: begin
            k_in     = count_ff >> 1;
            build_in = 1'b1;
         end
         ST_BUILD: begin
            if (k_ff != '0) begin
               node_in = AW'(k_ff - CW'(1));
               size_in = count_ff;
               k_in    = k_ff - CW'(1);
            end else begin
               build_in = 1'b0;
               k_in     = count_ff;
            end
         end
         ST_RD_NODE: begin
            rd_en = 1'b1;
         end
         ST_GET_NODE: begin
            cur_in = rd_data;
         end
         ST_DESCEND: begin
            if (lc_in_heap) begin
               rd_en   = 1'b1;
               rd_addr = lc[AW-1:0];
            end else begin
               // hole is a leaf: drop the sifted value here
               wr_en = 1'b1;
            end
         end
         ST_GET_LEFT: begin
            best_in     = rd_data;
            best_idx_in = lc[AW-1:0];
            if (rc_in_heap) begin
               rd_en   = 1'b1;
               rd_addr = rc[AW-1:0];
            end
         end
         ST_GET_RIGHT: begin
            if (cmp_gt) begin
               best_in     = rd_data;
               best_idx_in = rc[AW-1:0];
            end
         end
         ST_CMP: begin
            wr_en = 1'b1;
            if (cmp_gt) begin
               // larger child moves up, hole moves down
               wr_data = best_ff;
               node_in = best_idx_ff;
            end
         end
         ST_EXTRACT: begin
            if (k_ff > CW'(1)) begin
               k_in = k_ff - CW'(1);
            end else begin
               emit_in = '0;
            end
         end
         ST_EX_RD0: begin
            rd_en   = 1'b1;
            rd_addr = '0;
         end
         ST_EX_RDL: begin
            best_in = rd_data;
            rd_en   = 1'b1;
            rd_addr = k_ff[AW-1:0];
         end
         ST_EX_SWAP: begin
            // old root goes to the end, the end value sifts from the root
            cur_in  = rd_data;
            wr_en   = 1'b1;
            wr_addr = k_ff[AW-1:0];
            wr_data = best_ff;
            size_in = k_ff;
            node_in = '0;
         end
         ST_EMIT_RD: begin
            rd_en   = 1'b1;
            rd_addr = emit_ff;
         end
         ST_EMIT_LOAD: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = rd_data;
               rsp_last_in  = emit_last;
               rsp_ovf_in   = ovf_ff;
               if (emit_last) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
               end else begin
                  emit_in = emit_ff + AW'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         build_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         build_ff     <= build_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and index registers
   always_ff @(posedge clock) begin
      k_ff         <= k_in;
      node_ff      <= node_in;
      size_ff      <= size_in;
      emit_ff      <= emit_in;
      cur_ff       <= cur_in;
      best_ff      <= best_in;
      best_idx_ff  <= best_idx_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_value_res  = rsp_value_ff;
   assign rsp_last_res   = rsp_last_ff;
   assign rsp_overflowed = rsp_ovf_ff;

`ifndef SYNTHESIS
   // stored count never passes capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("element count above capacity");

   // a new result appears only from the readout state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_EMIT_LOAD)
      else $error("result loaded outside readout");

   // heap under sift never exceeds the stored set
   a_size_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DESCEND |-> size_ff <= count_ff)
      else $error("heap size above element count");

   // loading the greatest value ends the set and reopens the input
   a_set_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT_LOAD && rsp_free && emit_last)
      |=> (state_ff == ST_LOAD && count_ff == '0 && !ovf_ff && rsp_last_ff))
      else $error("set not closed after final result");
`endif

endmodule
